// ===== hdl/chained_byte_stream_cipher_defines.svh =====
// ----------------------------------------------------------------------------
// chained byte stream cipher assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef CHAINED_BYTE_STREAM_CIPHER_DEFINES_SVH
`define CHAINED_BYTE_STREAM_CIPHER_DEFINES_SVH

// same-cycle implication
`define CBSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbsc same-cycle check failed");

// next-cycle implication
`define CBSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbsc next-cycle check failed");

`endif

// ===== hdl/cbsc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbsc_pkg
// widths, register indexes and byte transforms of the chained byte cipher
// ----------------------------------------------------------------------------
package cbsc_pkg;

    localparam int BYTE_W = 8;
    localparam int PK_W   = 4;
    localparam int CFG_W  = 4;
    localparam int IDX_W  = 1;

    localparam logic [IDX_W-1:0] CFG_PARTIAL_KEY  = 1'd0;
    localparam logic [IDX_W-1:0] CFG_DECRYPT_MODE = 1'd1;

    localparam logic [PK_W-1:0]   PK_RESET = 4'd1;
    localparam logic [BYTE_W-1:0] CHAIN_IV = 8'hCB;

    typedef logic [BYTE_W-1:0] byte_t;

    // high nibble is the key, low bits 2,1,0,3 invert bits 7,6,5,4
    function automatic byte_t expand_seed(input logic [PK_W-1:0] pk);
        expand_seed = {pk, ~pk[0], ~pk[3], ~pk[2], ~pk[1]};
    endfunction

    // base-4 digit sum, folded once more
    function automatic logic div_by_3(input byte_t v);
        logic [3:0] s;
        logic [2:0] t;
        s = {2'b00, v[7:6]} + {2'b00, v[5:4]} + {2'b00, v[3:2]} + {2'b00, v[1:0]};
        t = {1'b0, s[3:2]} + {1'b0, s[1:0]};
        div_by_3 = (t == 3'd0) || (t == 3'd3) || (t == 3'd6);
    endfunction

    function automatic byte_t advance_key(input byte_t key);
        byte_t k2;
        k2 = {key[5:0], key[7:6]};
        advance_key = div_by_3(k2) ? {k2[6:0], k2[7]} : k2;
    endfunction

    localparam byte_t KEY_RESET = expand_seed(PK_RESET);

    // bit i uses chain bit (7 - i + n) mod 8, n the key ones in bits i..0
    function automatic byte_t cipher_byte(input byte_t data, input byte_t chain,
                                          input byte_t key);
        logic [2:0] rot;
        logic [2:0] idx;
        byte_t      res;
        rot = '0;
        res = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            rot    = rot + {2'b00, key[i]};
            idx    = 3'(BYTE_W - 1 - i) + rot;
            res[i] = data[i] ^ chain[idx];
        end
        cipher_byte = res;
    endfunction

endpackage

// ===== hdl/cbsc_ifs.sv =====
// ----------------------------------------------------------------------------
// cbsc stream interfaces
// valid/ready channels for input bytes and result bytes
// ----------------------------------------------------------------------------
interface cbsc_item_if;
    logic                       valid;
    logic                       ready;
    logic [cbsc_pkg::BYTE_W-1:0] data_in;
    logic                       first_byte;

    modport source (output valid, output data_in, output first_byte, input ready);
    modport sink   (input valid, input data_in, input first_byte, output ready);
endinterface

interface cbsc_result_if;
    logic                       valid;
    logic                       ready;
    logic [cbsc_pkg::BYTE_W-1:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

// ===== hdl/chained_byte_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// chained_byte_stream_cipher
// byte-wise chained stream cipher, encrypt or decrypt, one byte per cycle
//
// item channel: data_in plus first_byte; first_byte restarts the message
//   (running key reloaded from the expanded partial key, chain set to 0xCB)
// result channel: data_out, exactly one transaction per item transaction
// config port: cfg_wr_en writes cfg_data to register cfg_index
//   (0 partial_key, 1 decrypt_mode); write only while the block is idle
// latency: an item accepted at edge n gives a result valid after edge n+1
//   (input register, then result register)
// throughput: one item per cycle; the key and chain update from one byte to
//   the next sits in the single cycle between input and result register
// stall: while the result is held, one more item sits in the input register,
//   then item.ready drops until the result is taken
// reset: key seed of partial key 1 (0x17), chain 0xCB, decrypt_mode 0,
//   both channels empty
// ----------------------------------------------------------------------------
`include "chained_byte_stream_cipher_defines.svh"

module chained_byte_stream_cipher
(
    input  logic                          clk,
    input  logic                          rst_n,
    cbsc_item_if.sink                     item,
    cbsc_result_if.source                 result,
    input  logic                          cfg_wr_en,
    input  logic [cbsc_pkg::IDX_W-1:0]    cfg_index,
    input  logic [cbsc_pkg::CFG_W-1:0]    cfg_data
);

    logic [cbsc_pkg::PK_W-1:0] partial_key_reg;
    logic                      decrypt_mode_reg;

    cbsc_pkg::byte_t running_key_reg;
    cbsc_pkg::byte_t running_key_next;
    cbsc_pkg::byte_t chain_reg;
    cbsc_pkg::byte_t chain_next;

    logic            s1_valid_reg;
    cbsc_pkg::byte_t s1_data_reg;
    logic            s1_first_reg;

    logic            out_valid_reg;
    cbsc_pkg::byte_t out_data_reg;

    logic            item_fire;
    logic            s1_advance;
    cbsc_pkg::byte_t key_base;
    cbsc_pkg::byte_t chain_base;
    cbsc_pkg::byte_t cipher_out;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_key_reg  <= cbsc_pkg::PK_RESET;
            decrypt_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                cbsc_pkg::CFG_PARTIAL_KEY:  partial_key_reg  <= cfg_data;
                cbsc_pkg::CFG_DECRYPT_MODE: decrypt_mode_reg <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // handshake
    assign s1_advance  = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready  = !s1_valid_reg || s1_advance;
    assign item_fire   = item.valid && item.ready;

    // byte transform
    always_comb
    begin
        key_base         = s1_first_reg ? cbsc_pkg::expand_seed(partial_key_reg)
                                        : running_key_reg;
        chain_base       = s1_first_reg ? cbsc_pkg::CHAIN_IV : chain_reg;
        running_key_next = cbsc_pkg::advance_key(key_base);
        cipher_out       = cbsc_pkg::cipher_byte(s1_data_reg, chain_base, running_key_next);
        chain_next       = decrypt_mode_reg ? s1_data_reg : cipher_out;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_data_reg  <= item.data_in;
            s1_first_reg <= item.first_byte;
        end
    end

    // cipher state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_key_reg <= cbsc_pkg::KEY_RESET;
            chain_reg       <= cbsc_pkg::CHAIN_IV;
        end
        else if (s1_advance)
        begin
            running_key_reg <= running_key_next;
            chain_reg       <= chain_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_data_reg <= cipher_out;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.data_out = out_data_reg;

    `CBSC_ASSERT_SAME(a_full_accept_moves, item_fire && s1_valid_reg, s1_advance)
    `CBSC_ASSERT_NEXT(a_advance_fills_out, s1_advance, out_valid_reg)
    `CBSC_ASSERT_NEXT(a_enc_chain_is_out, s1_advance && !decrypt_mode_reg,
                      chain_reg == out_data_reg)
    `CBSC_ASSERT_NEXT(a_dec_chain_is_in, s1_advance && decrypt_mode_reg,
                      chain_reg == $past(s1_data_reg))

endmodule
